@@ rtl/core/ddrt_pkg.sv @@
package ddrt_pkg;

    localparam int MAX_SCREEN_DIM = 4096;
    localparam int AREA_DIVISOR   = 3;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int POS_W   = 16;
    localparam int SUM_W   = 18;
    localparam int AREA_W  = 2 * COORD_W + 1;
    localparam int CMP_W   = AREA_W + 2;

    localparam int REG_ADDR_W = 4;
    localparam int REG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_ORIGIN_COL    = 2'd2,
        REG_ORIGIN_ROW    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ACT_MARK_ABS   = 3'd0,
        ACT_MARK_REL   = 3'd1,
        ACT_FLUSH      = 3'd2,
        ACT_FORCE_FULL = 3'd3,
        ACT_DISCARD    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        UPD_NONE      = 2'd0,
        UPD_REGION    = 2'd1,
        UPD_FULL      = 2'd2,
        UPD_FULL_SLOW = 2'd3
    } update_kind_t;

    // Screen settings as seen by the tracking engine
    typedef struct packed {
        logic [DIM_W-1:0]   scr_w;
        logic [DIM_W-1:0]   scr_h;
        logic [AREA_W-1:0]  scr_area;
        logic [COORD_W-1:0] origin_col;
        logic [COORD_W-1:0] origin_row;
    } scr_cfg_t;

    typedef struct packed {
        update_kind_t       kind;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [DIM_W-1:0]   cols;
        logic [DIM_W-1:0]   rows;
        logic               pending;
    } result_t;

    // Saturate a screen dimension to 1..MAX_SCREEN_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
                r = DIM_W'(1);
            else if (v > DIM_W'(MAX_SCREEN_DIM))
                r = DIM_W'(MAX_SCREEN_DIM);
            else
                r = v;
            return r;
        end
    endfunction

    // Clamp a signed coordinate to 0..dim-1
    function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                       input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0]   lim;
        logic [COORD_W-1:0] r;
        begin
            lim = dim - DIM_W'(1);
            if (v[SUM_W-1])
                r = '0;
            else if (v[SUM_W-2:0] > (SUM_W-1)'(lim))
                r = lim[COORD_W-1:0];
            else
                r = v[COORD_W-1:0];
            return r;
        end
    endfunction

endpackage

@@ rtl/core/ddrt_cfg.sv @@
module ddrt_cfg
    import ddrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready,
    output scr_cfg_t              cfg
);

    logic [DIM_W-1:0]   width_reg,  width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [DIM_W-1:0]   eff_w_reg,  eff_w_next;
    logic [DIM_W-1:0]   eff_h_reg,  eff_h_next;
    logic [AREA_W-1:0]  area_reg,   area_next;
    logic [COORD_W-1:0] ocol_reg,   ocol_next;
    logic [COORD_W-1:0] orow_reg,   orow_next;
    logic               wr_en;
    reg_idx_t           idx;
    logic [DIM_W-1:0]   wr_eff;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_eff = eff_dim(pwdata[DIM_W-1:0]);

    // Keep the screen area ready so a flush only multiplies the box
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        eff_w_next  = eff_w_reg;
        eff_h_next  = eff_h_reg;
        area_next   = area_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SCREEN_WIDTH:
                begin
                    width_next = pwdata[DIM_W-1:0];
                    eff_w_next = wr_eff;
                    area_next  = AREA_W'(wr_eff) * AREA_W'(eff_h_reg);
                end
                REG_SCREEN_HEIGHT:
                begin
                    height_next = pwdata[DIM_W-1:0];
                    eff_h_next  = wr_eff;
                    area_next   = AREA_W'(eff_w_reg) * AREA_W'(wr_eff);
                end
                REG_ORIGIN_COL: ocol_next = pwdata[COORD_W-1:0];
                REG_ORIGIN_ROW: orow_next = pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(960);
            height_reg <= DIM_W'(540);
            eff_w_reg  <= DIM_W'(960);
            eff_h_reg  <= DIM_W'(540);
            area_reg   <= AREA_W'(960 * 540);
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            eff_w_reg  <= eff_w_next;
            eff_h_reg  <= eff_h_next;
            area_reg   <= area_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_SCREEN_WIDTH:  prdata = REG_DATA_W'(width_reg);
            REG_SCREEN_HEIGHT: prdata = REG_DATA_W'(height_reg);
            REG_ORIGIN_COL:    prdata = REG_DATA_W'(ocol_reg);
            REG_ORIGIN_ROW:    prdata = REG_DATA_W'(orow_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.scr_w      = eff_w_reg;
    assign cfg.scr_h      = eff_h_reg;
    assign cfg.scr_area   = area_reg;
    assign cfg.origin_col = ocol_reg;
    assign cfg.origin_row = orow_reg;

endmodule

@@ rtl/core/ddrt_engine.sv @@
module ddrt_engine
    import ddrt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  action_t                 action,
    input  logic signed [POS_W-1:0] x_pos,
    input  logic signed [POS_W-1:0] y_pos,
    input  logic signed [POS_W-1:0] region_width,
    input  logic signed [POS_W-1:0] region_height,
    input  scr_cfg_t                cfg,
    output result_t                 res
);

    logic               valid_reg,  valid_next;
    logic               first_reg,  first_next;
    logic [COORD_W-1:0] left_reg,   left_next;
    logic [COORD_W-1:0] top_reg,    top_next;
    logic [COORD_W-1:0] right_reg,  right_next;
    logic [COORD_W-1:0] bottom_reg, bottom_next;

    logic signed [SUM_W-1:0] xa, ya, xe, ye;
    logic [COORD_W-1:0]      x1, y1, x2, y2;
    logic                    rect_ok;
    logic [DIM_W-1:0]        bw, bh;
    logic [AREA_W-1:0]       box_area;
    logic [CMP_W-1:0]        box_scaled;
    logic                    small_box;
    logic                    is_rel;

    assign is_rel = (action == ACT_MARK_REL);

    // Corners of the marked rectangle, clamped to the screen
    assign xa = SUM_W'(x_pos) + (is_rel ? SUM_W'(cfg.origin_col) : '0);
    assign ya = SUM_W'(y_pos) + (is_rel ? SUM_W'(cfg.origin_row) : '0);
    assign xe = xa + SUM_W'(region_width) - SUM_W'(1);
    assign ye = ya + SUM_W'(region_height) - SUM_W'(1);
    assign x1 = clamp_coord(xa, cfg.scr_w);
    assign y1 = clamp_coord(ya, cfg.scr_h);
    assign x2 = clamp_coord(xe, cfg.scr_w);
    assign y2 = clamp_coord(ye, cfg.scr_h);
    assign rect_ok = (region_width > 0) && (region_height > 0);

    // area < screen/3 is the same as 3*(area+1) <= screen
    assign bw         = DIM_W'(right_reg) - DIM_W'(left_reg) + DIM_W'(1);
    assign bh         = DIM_W'(bottom_reg) - DIM_W'(top_reg) + DIM_W'(1);
    assign box_area   = AREA_W'(bw) * AREA_W'(bh);
    assign box_scaled = CMP_W'((CMP_W'(box_area) + CMP_W'(1)) * CMP_W'(AREA_DIVISOR));
    assign small_box  = box_scaled <= CMP_W'(cfg.scr_area);

    always_comb
    begin
        valid_next  = valid_reg;
        first_next  = first_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        res.kind    = UPD_NONE;
        res.left    = '0;
        res.top     = '0;
        res.cols    = '0;
        res.rows    = '0;
        case (action)
            ACT_MARK_ABS, ACT_MARK_REL:
            begin
                if (rect_ok)
                begin
                    valid_next = 1'b1;
                    if (!valid_reg)
                    begin
                        left_next   = x1;
                        top_next    = y1;
                        right_next  = x2;
                        bottom_next = y2;
                    end
                    else
                    begin
                        left_next   = (x1 < left_reg)   ? x1 : left_reg;
                        top_next    = (y1 < top_reg)    ? y1 : top_reg;
                        right_next  = (x2 > right_reg)  ? x2 : right_reg;
                        bottom_next = (y2 > bottom_reg) ? y2 : bottom_reg;
                    end
                end
            end
            ACT_FLUSH:
            begin
                if (valid_reg)
                begin
                    if (!first_reg && small_box)
                    begin
                        res.kind = UPD_REGION;
                        res.left = left_reg;
                        res.top  = top_reg;
                        res.cols = bw;
                        res.rows = bh;
                    end
                    else
                    begin
                        res.kind   = first_reg ? UPD_FULL_SLOW : UPD_FULL;
                        res.cols   = cfg.scr_w;
                        res.rows   = cfg.scr_h;
                        first_next = 1'b0;
                    end
                    valid_next  = 1'b0;
                    left_next   = '0;
                    top_next    = '0;
                    right_next  = '0;
                    bottom_next = '0;
                end
            end
            ACT_FORCE_FULL: first_next = 1'b1;
            ACT_DISCARD:
            begin
                valid_next  = 1'b0;
                left_next   = '0;
                top_next    = '0;
                right_next  = '0;
                bottom_next = '0;
            end
            default: ;
        endcase
        res.pending = valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            first_reg  <= 1'b1;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end
        else if (step)
        begin
            valid_reg  <= valid_next;
            first_reg  <= first_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
        end
    end

endmodule

@@ rtl/core/display_dirty_region_tracker_core.sv @@
// Dirty-region tracker for an e-paper panel. Each input beat carries an action
// (mark absolute, mark relative to the content origin, flush, force a full
// refresh, discard) and produces exactly one output beat. Marks grow a single
// bounding box, clamped to the screen; a flush turns the box into a region
// update when its area is under a third of the screen and the first refresh
// has been done, otherwise into a full update (with slow clear on the first
// refresh), and empties the box. Throughput is one beat per clock while the
// output is not stalled. The accepting edge loads the input register; the
// result register loads as the held beat moves on. A stalled output holds
// the input register, and the stall reaches s_axis_tready in the same cycle.
// The box update, clamp and area compare all sit in the single stage between
// the two registers. The user must set screen size and origin over the APB
// port while no beat is in flight; the block does not enforce this.
module display_dirty_region_tracker_core
    import ddrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_pos[15:0], y_pos[31:16], region_width[47:32], region_height[63:48]
    input  logic [63:0]           s_axis_tdata,
    // action[2:0]
    input  logic [2:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rect_left[11:0], rect_top[23:12], rect_cols[36:24], rect_rows[49:37],
    // region_pending[50], zero[55:51]
    output logic [55:0]           m_axis_tdata,
    // update_kind[1:0]
    output logic [1:0]            m_axis_tuser
);

    scr_cfg_t cfg;
    result_t  res;

    // Input register
    logic                    in_valid_reg;
    action_t                 in_action_reg;
    logic signed [POS_W-1:0] in_x_reg, in_y_reg, in_w_reg, in_h_reg;

    // Result register
    logic                    out_valid_reg;
    result_t                 out_res_reg;

    logic                    advance;
    logic                    s_take;

    // Move the held beat on whenever the result register is empty or draining
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign s_take        = s_axis_tvalid & s_axis_tready;

    ddrt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddrt_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .action        (in_action_reg),
        .x_pos         (in_x_reg),
        .y_pos         (in_y_reg),
        .region_width  (in_w_reg),
        .region_height (in_h_reg),
        .cfg           (cfg),
        .res           (res)
    );

    // Control: valid flags of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: capture the incoming beat and the finished result
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_action_reg <= action_t'(s_axis_tuser);
            in_x_reg      <= s_axis_tdata[15:0];
            in_y_reg      <= s_axis_tdata[31:16];
            in_w_reg      <= s_axis_tdata[47:32];
            in_h_reg      <= s_axis_tdata[63:48];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {5'b0, out_res_reg.pending, out_res_reg.rows, out_res_reg.cols,
                            out_res_reg.top, out_res_reg.left};

endmodule

@@ dv/display_dirty_region_tracker_core_tb.sv @@
module display_dirty_region_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddrt_pkg::*;

    // Run length and pacing
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int GAP_MAX         = 8;
    localparam int SCREEN_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 125;

    // Reserved action codes: the block must ignore these
    localparam logic [2:0] ACT_RSVD_LO = 3'd5;
    localparam logic [2:0] ACT_RSVD_HI = 3'd7;

    // Screen settings per random phase; the last phase draws its own values.
    // Zero and anything above the maximum dimension must saturate.
    int phase_w[SCREEN_PHASES]   = '{960, 1, 4096,  0, 8191, 320,   17, 0};
    int phase_h[SCREEN_PHASES]   = '{540, 1, 4096,  0, 8191, 240, 4095, 0};
    int phase_oc[SCREEN_PHASES]  = '{  0, 0, 4095, 17,    0, 100, 4095, 0};
    int phase_or[SCREEN_PHASES]  = '{  0, 0, 4095,  9, 4095,  50,    0, 0};

    logic                  clk;
    logic                  rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [REG_DATA_W-1:0] pwdata = '0;
    logic [REG_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [55:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    display_dirty_region_tracker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Handshake sampling. Inputs and DUT outputs only move at the rising
    // edge, so whatever holds at the falling edge is what the next rising
    // edge sees. Latch it here and let the edge-driven processes act on it,
    // which keeps every decision clear of ordering within a time step.
    // ------------------------------------------------------------------
    bit          in_fire;
    bit          out_fire;
    bit          apb_fire;
    logic [55:0] out_word;
    logic [1:0]  out_kind;

    always @(negedge clk)
    begin
        in_fire  = s_axis_tvalid && s_axis_tready;
        out_fire = m_axis_tvalid && m_axis_tready;
        apb_fire = psel && penable && pwrite && pready;
        out_word = m_axis_tdata;
        out_kind = m_axis_tuser;
    end

    // Watchdog: abandon the run once the cycle count reaches CYCLE_LIMIT
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL display_dirty_region_tracker_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tracker model: register copies, the damage box and the refresh flag
    // ------------------------------------------------------------------
    logic [12:0] scr_w_reg = 13'd960;
    logic [12:0] scr_h_reg = 13'd540;
    logic [11:0] org_c_reg = '0;
    logic [11:0] org_r_reg = '0;

    bit dmg_valid     = 1'b0;
    bit refresh_first = 1'b1;
    int dmg_l = 0;
    int dmg_t = 0;
    int dmg_r = 0;
    int dmg_b = 0;

    result_t updates_due[$];
    int      mismatch_count = 0;

    // Flow-control moods: a calm side runs back to back for a while
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;

    function automatic int sat_dim(input logic [12:0] v);
        if (v == '0)
            return 1;
        if (v > 13'(MAX_SCREEN_DIM))
            return MAX_SCREEN_DIM;
        return int'(v);
    endfunction

    function automatic int clip(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void drop_box();
        dmg_valid = 1'b0;
        dmg_l = 0;
        dmg_t = 0;
        dmg_r = 0;
        dmg_b = 0;
    endfunction

    // Clamp the rectangle to the screen and fold it into the damage box
    function automatic void grow_box(input int x, input int y, input int w, input int h,
                                     input int sw, input int sh);
        int x1;
        int y1;
        int x2;
        int y2;
        if (w <= 0 || h <= 0)
            return;
        x1 = clip(x, sw - 1);
        y1 = clip(y, sh - 1);
        x2 = clip(x + w - 1, sw - 1);
        y2 = clip(y + h - 1, sh - 1);
        if (!dmg_valid)
        begin
            dmg_l = x1;
            dmg_t = y1;
            dmg_r = x2;
            dmg_b = y2;
            dmg_valid = 1'b1;
            return;
        end
        if (x1 < dmg_l) dmg_l = x1;
        if (y1 < dmg_t) dmg_t = y1;
        if (x2 > dmg_r) dmg_r = x2;
        if (y2 > dmg_b) dmg_b = y2;
    endfunction

    // Advance the model by one input beat and return the update it causes
    function automatic result_t predict_update(input logic [2:0] act, input logic [63:0] data);
        result_t r;
        int      x;
        int      y;
        int      w;
        int      h;
        int      sw;
        int      sh;
        int      bw;
        int      bh;
        x  = int'($signed(data[15:0]));
        y  = int'($signed(data[31:16]));
        w  = int'($signed(data[47:32]));
        h  = int'($signed(data[63:48]));
        sw = sat_dim(scr_w_reg);
        sh = sat_dim(scr_h_reg);
        r  = '0;
        case (act)
            ACT_MARK_ABS:
                grow_box(x, y, w, h, sw, sh);
            ACT_MARK_REL:
                grow_box(x + int'(org_c_reg), y + int'(org_r_reg), w, h, sw, sh);
            ACT_FLUSH:
                if (dmg_valid)
                begin
                    bw = dmg_r - dmg_l + 1;
                    bh = dmg_b - dmg_t + 1;
                    if (!refresh_first && bw * bh < (sw * sh) / AREA_DIVISOR)
                    begin
                        r.kind = UPD_REGION;
                        r.left = COORD_W'(dmg_l);
                        r.top  = COORD_W'(dmg_t);
                        r.cols = DIM_W'(bw);
                        r.rows = DIM_W'(bh);
                    end
                    else
                    begin
                        if (refresh_first)
                            r.kind = UPD_FULL_SLOW;
                        else
                            r.kind = UPD_FULL;
                        r.cols = DIM_W'(sw);
                        r.rows = DIM_W'(sh);
                        refresh_first = 1'b0;
                    end
                    drop_box();
                end
            ACT_FORCE_FULL:
                refresh_first = 1'b1;
            ACT_DISCARD:
                drop_box();
            default:
                ;
        endcase
        r.pending = dmg_valid;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Register writes over APB: setup beat, then access beat until pready.
    // psel stays up between back-to-back writes; set_screen drops it.
    // ------------------------------------------------------------------
    task automatic write_reg(input reg_idx_t idx, input int value);
        logic [REG_DATA_W-1:0] word;
        int                    keep;
        if (idx == REG_SCREEN_WIDTH || idx == REG_SCREEN_HEIGHT)
            keep = DIM_W;
        else
            keep = COORD_W;
        // Junk above the register width must be dropped by the block
        word = ($urandom << keep) | REG_DATA_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADDR_W'(4 * int'(idx));
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!apb_fire);
        case (idx)
            REG_SCREEN_WIDTH:  scr_w_reg = word[12:0];
            REG_SCREEN_HEIGHT: scr_h_reg = word[12:0];
            REG_ORIGIN_COL:    org_c_reg = word[11:0];
            REG_ORIGIN_ROW:    org_r_reg = word[11:0];
            default:           ;
        endcase
    endtask

    task automatic set_screen(input int w, input int h, input int oc, input int orow);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_ORIGIN_COL, oc);
        write_reg(REG_ORIGIN_ROW, orow);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input side: hold off for a random gap, present the beat, wait for the
    // handshake, then queue the update it must cause. tvalid is only
    // lowered when a gap follows, so back-to-back beats never see a
    // low-then-high pair in one step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] act, input logic [63:0] data,
                             input bit typed, input result_t want);
        int      gap;
        result_t due;
        if ($urandom_range(0, 63) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= act;
        do @(posedge clk); while (!in_fire);
        // The model always advances; a typed-in expectation overrides its answer
        due = predict_update(act, data);
        if (typed)
            due = want;
        updates_due.push_back(due);
    endtask

    // Random beat: every action, reserved ones too. Most marks are rectangles near
    // the screen so boxes build up and both region and full updates occur; the
    // rest of the marks are raw 16-bit noise, and some rectangles are empty.
    task automatic make_item(output logic [2:0] act, output logic [63:0] data);
        int pick;
        int sw;
        int sh;
        int x;
        int y;
        int w;
        int h;
        sw   = sat_dim(scr_w_reg);
        sh   = sat_dim(scr_h_reg);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            act = ACT_MARK_ABS;
        else if (pick < 60)
            act = ACT_MARK_REL;
        else if (pick < 80)
            act = ACT_FLUSH;
        else if (pick < 86)
            act = ACT_FORCE_FULL;
        else if (pick < 93)
            act = ACT_DISCARD;
        else
            act = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
        data = {$urandom, $urandom};
        if ((act == ACT_MARK_ABS || act == ACT_MARK_REL) && $urandom_range(0, 4) != 0)
        begin
            x = $urandom_range(0, sw + 31) - 16;
            y = $urandom_range(0, sh + 31) - 16;
            if ($urandom_range(0, 3) == 0)
            begin
                w = $urandom_range(1, sw + 32);
                h = $urandom_range(1, sh + 32);
            end
            else
            begin
                w = $urandom_range(1, sw / 8 + 1);
                h = $urandom_range(1, sh / 8 + 1);
            end
            if ($urandom_range(0, 19) == 0)
                w = -$urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0)
                h = -$urandom_range(0, 3);
            // Relative marks land at the same spot once the origin is added back
            if (act == ACT_MARK_REL)
            begin
                x = x - int'(org_c_reg);
                y = y - int'(org_r_reg);
            end
            data = {16'(h), 16'(w), 16'(y), 16'(x)};
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stall for a random number of cycles before each beat,
    // then check the beat against the oldest queued update.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_update();
        result_t due;
        if (updates_due.size() == 0)
        begin
            $error("update beat with nothing outstanding: kind %0d data %h", out_kind, out_word);
            mismatch_count++;
            return;
        end
        due = updates_due.pop_front();
        check_field("update_kind", int'(due.kind), int'(out_kind));
        check_field("rect_left", int'(due.left), int'(out_word[11:0]));
        check_field("rect_top", int'(due.top), int'(out_word[23:12]));
        check_field("rect_cols", int'(due.cols), int'(out_word[36:24]));
        check_field("rect_rows", int'(due.rows), int'(out_word[49:37]));
        check_field("region_pending", int'(due.pending), int'(out_word[50]));
    endtask

    initial
    begin : result_sink
        int stall;
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!out_fire);
            check_update();
        end
    end

    // ------------------------------------------------------------------
    // Directed table: one row per beat. Typed rows carry the update that
    // follows plainly from reset values, clamping, empty rectangles and
    // reserved actions; the rest are left to the model.
    // ------------------------------------------------------------------
    logic [2:0]  dir_act[$];
    logic [63:0] dir_data[$];
    bit          dir_typed[$];
    result_t     dir_want[$];

    task automatic dir_row(input logic [2:0] act, input int x, input int y, input int w,
                           input int h, input bit typed, input update_kind_t k, input int l,
                           input int t, input int c, input int rw, input bit p);
        result_t want;
        want.kind    = k;
        want.left    = COORD_W'(l);
        want.top     = COORD_W'(t);
        want.cols    = DIM_W'(c);
        want.rows    = DIM_W'(rw);
        want.pending = p;
        dir_act.push_back(act);
        dir_data.push_back({16'(h), 16'(w), 16'(y), 16'(x)});
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    initial
    begin : stimulus
        logic [2:0]  act;
        logic [63:0] data;

        // Flush straight after reset: no box, nothing to do
        dir_row(ACT_FLUSH,           0,      0,     0,      0, 1, UPD_NONE,  0, 0, 0, 0, 0);
        // Far corner pulled in to the origin pixel, then the opposite corner
        dir_row(ACT_MARK_ABS,   -32768, -32768, 32767,  32767, 1, UPD_NONE,  0, 0, 0, 0, 1);
        dir_row(ACT_MARK_ABS,    32767,  32767, 32767,  32767, 1, UPD_NONE,  0, 0, 0, 0, 1);
        // First refresh is always full with slow clear
        dir_row(ACT_FLUSH,           0,      0,     0,      0, 1, UPD_FULL_SLOW,
                0, 0, 960, 540, 0);
        // Empty rectangles: zero width, negative width, most negative height
        dir_row(ACT_MARK_ABS,        5,      5,     0,      7, 1, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_MARK_ABS,        5,      5,    -1,      7, 1, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_MARK_ABS,        5,      5,     7, -32768, 1, UPD_NONE,  0, 0, 0, 0, 0);
        // Small box plus a relative mark hanging off the top-left: region update
        dir_row(ACT_MARK_ABS,       10,     20,    30,     40, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_MARK_REL,       -5,     -5,    10,     10, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_FLUSH,           0,      0,     0,      0, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_FLUSH,           0,      0,     0,      0, 1, UPD_NONE,  0, 0, 0, 0, 0);
        // Forced full refresh brings the slow clear back
        dir_row(ACT_FORCE_FULL,      0,      0,     0,      0, 1, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_MARK_REL,      100,    100,    10,     10, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_FLUSH,           0,      0,     0,      0, 1, UPD_FULL_SLOW,
                0, 0, 960, 540, 0);
        // Area exactly a third of the screen goes full; one row less goes region
        dir_row(ACT_MARK_ABS,        0,      0,   960,    180, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_FLUSH,           0,      0,     0,      0, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_MARK_ABS,        0,      0,   960,    179, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_FLUSH,           0,      0,     0,      0, 0, UPD_NONE,  0, 0, 0, 0, 0);
        // Discard drops a box clipped at the bottom-right edge
        dir_row(ACT_MARK_ABS,      958,    538,   100,    100, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_DISCARD,         0,      0,     0,      0, 1, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_FLUSH,           0,      0,     0,      0, 1, UPD_NONE,  0, 0, 0, 0, 0);
        // Reserved actions leave a held box alone
        dir_row(ACT_MARK_ABS,        1,      1,     1,      1, 0, UPD_NONE,  0, 0, 0, 0, 0);
        dir_row(ACT_RSVD_LO,        -1,     -1,    -1,     -1, 1, UPD_NONE,  0, 0, 0, 0, 1);
        dir_row(ACT_RSVD_HI,        -1,     -1,    -1,     -1, 1, UPD_NONE,  0, 0, 0, 0, 1);
        dir_row(ACT_DISCARD,        -1,     -1,    -1,     -1, 1, UPD_NONE,  0, 0, 0, 0, 0);

        // Hold reset, then release it for good
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_act[i])
            send_item(dir_act[i], dir_data[i], dir_typed[i], dir_want[i]);

        // Random phases. Let every update drain before touching the
        // registers; a box left over is kept across a screen change.
        for (int phase = 0; phase < SCREEN_PHASES; phase++)
        begin
            s_axis_tvalid <= 1'b0;
            while (updates_due.size() != 0)
                @(posedge clk);
            if (phase == SCREEN_PHASES - 1)
                set_screen($urandom_range(1, 1200), $urandom_range(1, 800),
                           $urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                set_screen(phase_w[phase], phase_h[phase], phase_oc[phase], phase_or[phase]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                make_item(act, data);
                send_item(act, data, 1'b0, '0);
            end
        end

        // Drain, then idle for SETTLE_CYCLES so the pipeline can show any stray beat
        s_axis_tvalid <= 1'b0;
        while (updates_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS display_dirty_region_tracker_core");
        else
            $display("FAIL display_dirty_region_tracker_core");
        $finish;
    end

endmodule
